// ----- design/barycentric_depth_test_core_macros.svh -----
// Assertion helpers, used by the back end.
`ifndef BARYCENTRIC_DEPTH_TEST_CORE_MACROS_SVH
`define BARYCENTRIC_DEPTH_TEST_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define BDT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define BDT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/bdt_pkg.sv -----
package bdt_pkg;

    // Width of the effective image dimensions (covers register and parameter range).
    localparam int DIMW = 11;

    // Register byte addresses on the configuration port.
    localparam logic [2:0] ADDR_IMAGE_WIDTH  = 3'd0;
    localparam logic [2:0] ADDR_IMAGE_HEIGHT = 3'd4;

    // Minimum depth, the value of every store entry after reset.
    localparam logic [15:0] DEPTH_MIN = 16'h8000;

    // One classified item as it travels from the front to the back.
    typedef struct packed {
        logic               oob;
        logic signed [16:0] e0x;
        logic signed [16:0] e0y;
        logic signed [16:0] e1x;
        logic signed [16:0] e1y;
        logic signed [16:0] e2x;
        logic signed [16:0] e2y;
        logic signed [15:0] az;
        logic signed [15:0] bz;
        logic signed [15:0] cz;
    } t_job;

    // Status that the back reports to the front.
    typedef struct packed {
        logic clearing;
        logic busy;
    } t_bstat;

    // Saturate a wide weight to Q2.16.
    function automatic logic signed [17:0] sat_w(input logic signed [55:0] v);
        logic signed [17:0] r;
        if (v > 56'sd131071) begin
            r = 18'sh1FFFF;
        end else if (v < -56'sd131072) begin
            r = 18'sh20000;
        end else begin
            r = v[17:0];
        end
        return r;
    endfunction

    // Saturate a Q8.8 depth to 16 bits.
    function automatic logic signed [15:0] sat_z(input logic signed [19:0] v);
        logic signed [15:0] r;
        if (v > 20'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -20'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

// ----- design/bdt_ram.sv -----
module bdt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16384,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/bdt_fifo.sv -----
module bdt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic             o_full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_buf [DEPTH];
    logic [PW-1:0]    r_wptr;
    logic [PW-1:0]    r_rptr;
    logic [CW-1:0]    r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_data  = r_buf[r_rptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wptr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- design/bdt_front.sv -----
module bdt_front #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 128,
    parameter int AW         = 14
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic signed [15:0]  i_a_x,
    input  logic signed [15:0]  i_a_y,
    input  logic signed [15:0]  i_a_z,
    input  logic signed [15:0]  i_b_x,
    input  logic signed [15:0]  i_b_y,
    input  logic signed [15:0]  i_b_z,
    input  logic signed [15:0]  i_c_x,
    input  logic signed [15:0]  i_c_y,
    input  logic signed [15:0]  i_c_z,
    input  logic signed [8:0]   i_pixel_x,
    input  logic signed [8:0]   i_pixel_y,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  bdt_pkg::t_bstat     i_bstat,
    input  logic                i_full,
    output logic                o_push,
    output bdt_pkg::t_job       o_job,
    output logic [AW-1:0]       o_idx
);

    import bdt_pkg::*;

    logic [7:0]      r_image_width;
    logic [7:0]      r_image_height;
    logic [DIMW-1:0] w_eff;
    logic [DIMW-1:0] h_eff;
    logic [DIMW-1:0] px_u;
    logic [DIMW-1:0] py_u;
    logic [DIMW-1:0] row;
    logic [2*DIMW-1:0] idx_full;
    logic            in_bounds;
    logic            cfg_wr;

    // Configuration registers; pready is always high.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= 8'd128;
            r_image_height <= 8'd128;
        end else if (cfg_wr) begin
            if (paddr[2] == ADDR_IMAGE_HEIGHT[2]) begin
                r_image_height <= pwdata[7:0];
            end else begin
                r_image_width <= pwdata[7:0];
            end
        end
    end

    assign prdata = (paddr[2] == ADDR_IMAGE_HEIGHT[2]) ? {24'd0, r_image_height}
                                                       : {24'd0, r_image_width};

    // Effective image size, bounded by the store dimensions.
    assign w_eff = ({3'd0, r_image_width} > DIMW'(MAX_WIDTH)) ? DIMW'(MAX_WIDTH)
                                                              : {3'd0, r_image_width};
    assign h_eff = ({3'd0, r_image_height} > DIMW'(MAX_HEIGHT)) ? DIMW'(MAX_HEIGHT)
                                                                : {3'd0, r_image_height};

    // Bounds check and store index with the row flipped.
    assign px_u      = {3'd0, i_pixel_x[7:0]};
    assign py_u      = {3'd0, i_pixel_y[7:0]};
    assign in_bounds = !i_pixel_x[8] && (px_u < w_eff) && !i_pixel_y[8] && (py_u < h_eff);
    assign row       = h_eff - DIMW'(1) - py_u;
    assign idx_full  = (row * w_eff) + {{DIMW{1'b0}}, px_u};
    assign o_idx     = idx_full[AW-1:0];

    // Edge vectors relative to the first vertex, pixel taken to Q.4.
    always_comb begin
        o_job.oob = !in_bounds;
        o_job.e0x = {i_b_x[15], i_b_x} - {i_a_x[15], i_a_x};
        o_job.e0y = {i_b_y[15], i_b_y} - {i_a_y[15], i_a_y};
        o_job.e1x = {i_c_x[15], i_c_x} - {i_a_x[15], i_a_x};
        o_job.e1y = {i_c_y[15], i_c_y} - {i_a_y[15], i_a_y};
        o_job.e2x = {{4{i_pixel_x[8]}}, i_pixel_x, 4'd0} - {i_a_x[15], i_a_x};
        o_job.e2y = {{4{i_pixel_y[8]}}, i_pixel_y, 4'd0} - {i_a_y[15], i_a_y};
        o_job.az  = i_a_z;
        o_job.bz  = i_b_z;
        o_job.cz  = i_c_z;
    end

    // Items wait while the queue is full or the store is being cleared.
    assign o_stall = i_full || i_bstat.clearing;
    assign o_push  = i_valid && !o_stall;

endmodule

// ----- design/bdt_back.sv -----
`include "barycentric_depth_test_core_macros.svh"

module bdt_back #(
    parameter int STORE = 16384,
    parameter int AW    = 14
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_empty,
    input  bdt_pkg::t_job       i_job,
    input  logic [AW-1:0]       i_idx,
    output logic                o_pop,
    output bdt_pkg::t_bstat     o_bstat,
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_hit,
    output logic signed [17:0]  o_weight_u,
    output logic signed [17:0]  o_weight_v,
    output logic signed [17:0]  o_weight_w,
    output logic signed [15:0]  o_depth_out
);

    import bdt_pkg::*;

    typedef enum logic [8:0] {
        S_CLR  = 9'b000000001,
        S_IDLE = 9'b000000010,
        S_MUL  = 9'b000000100,
        S_DIV  = 9'b000001000,
        S_WGT  = 9'b000010000,
        S_DEP  = 9'b000100000,
        S_RD   = 9'b001000000,
        S_CMP  = 9'b010000000,
        S_DONE = 9'b100000000
    } t_state;

    localparam logic [5:0] DIV_LAST = 6'd52;

    t_state             r_state;
    logic [2:0]         r_step;
    t_job               r_job;
    logic [AW-1:0]      r_idx;
    logic [AW-1:0]      r_clr;
    logic signed [34:0] r_prod;
    logic signed [34:0] r_d;
    logic signed [34:0] r_nv;
    logic signed [34:0] r_nw;
    logic [36:0]        r_rem;
    logic [52:0]        r_quo;
    logic [5:0]         r_dcnt;
    logic               r_dsel;
    logic signed [53:0] r_v;
    logic signed [53:0] r_w;
    logic signed [17:0] r_su;
    logic signed [17:0] r_sv;
    logic signed [17:0] r_sw;
    logic               r_inside;
    logic signed [35:0] r_acc;
    logic signed [15:0] r_z;
    logic               r_hit;
    logic               r_zero;
    logic               r_o_valid;
    logic               r_o_hit;
    logic signed [17:0] r_o_u;
    logic signed [17:0] r_o_v;
    logic signed [17:0] r_o_w;
    logic signed [15:0] r_o_z;

    logic signed [17:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [34:0] mul_p;
    logic [34:0]        d_abs;
    logic [34:0]        nw_abs;
    logic [34:0]        nv_abs;
    logic [52:0]        dvd_v;
    logic [52:0]        dvd_w;
    logic [36:0]        div_m;
    logic [36:0]        rem_sh;
    logic               rem_ge;
    logic [36:0]        rem_nx;
    logic [52:0]        quo_nx;
    logic               q_neg;
    logic signed [53:0] q_s;
    logic signed [55:0] u_full;
    logic [15:0]        ram_rdata;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [15:0]        ram_wdata;
    logic               hit_now;
    logic               out_free;

    // Shared multiplier: cross products first, then depth terms.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_state == S_MUL) begin
            unique case (r_step)
                3'd0: begin mul_a = 18'(r_job.e0x); mul_b = r_job.e1y; end
                3'd1: begin mul_a = 18'(r_job.e0y); mul_b = r_job.e1x; end
                3'd2: begin mul_a = 18'(r_job.e2x); mul_b = r_job.e1y; end
                3'd3: begin mul_a = 18'(r_job.e2y); mul_b = r_job.e1x; end
                3'd4: begin mul_a = 18'(r_job.e0x); mul_b = r_job.e2y; end
                3'd5: begin mul_a = 18'(r_job.e0y); mul_b = r_job.e2x; end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end else if (r_state == S_DEP) begin
            unique case (r_step)
                3'd0: begin mul_a = r_su; mul_b = 17'(r_job.az); end
                3'd1: begin mul_a = r_sv; mul_b = 17'(r_job.bz); end
                3'd2: begin mul_a = r_sw; mul_b = 17'(r_job.cz); end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end
    end

    assign mul_p = mul_a * mul_b;

    // Restoring divider, one quotient bit per cycle.
    assign d_abs  = r_d[34] ? 35'(-r_d) : 35'(r_d);
    assign nv_abs = r_nv[34] ? 35'(-r_nv) : 35'(r_nv);
    assign nw_abs = r_nw[34] ? 35'(-r_nw) : 35'(r_nw);
    assign dvd_v  = {1'b0, nv_abs, 17'd0} + {18'd0, d_abs};
    assign dvd_w  = {1'b0, nw_abs, 17'd0} + {18'd0, d_abs};
    assign div_m  = {1'b0, d_abs, 1'b0};
    assign rem_sh = {r_rem[35:0], r_quo[52]};
    assign rem_ge = (rem_sh >= div_m);
    assign rem_nx = rem_ge ? (rem_sh - div_m) : rem_sh;
    assign quo_nx = {r_quo[51:0], rem_ge};
    assign q_neg  = (r_dsel ? r_nw[34] : r_nv[34]) ^ r_d[34];
    assign q_s    = q_neg ? -$signed({1'b0, quo_nx}) : $signed({1'b0, quo_nx});

    // Third weight from the other two.
    assign u_full = 56'sd65536 - 56'(r_v) - 56'(r_w);

    // Depth test against the stored value.
    assign hit_now = r_inside && (r_z >= $signed(ram_rdata));

    // Store port: clearing pass, or the write of a hit.
    always_comb begin
        if (r_state == S_CLR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr;
            ram_wdata = DEPTH_MIN;
        end else begin
            ram_we    = (r_state == S_CMP) && hit_now;
            ram_waddr = r_idx;
            ram_wdata = r_z;
        end
    end

    bdt_ram #(
        .WIDTH (16),
        .DEPTH (STORE),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (r_state == S_RD),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign out_free = !r_o_valid || !i_stall;
    assign o_pop    = (r_state == S_IDLE) && !i_empty;

    assign o_bstat.clearing = (r_state == S_CLR);
    assign o_bstat.busy     = (r_state != S_IDLE);

    // Item payload and datapath registers.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
            r_idx <= i_idx;
        end
        if (r_state == S_MUL || r_state == S_DEP) begin
            r_prod <= mul_p;
        end
        if (r_state == S_MUL) begin
            unique case (r_step)
                3'd1: r_d  <= r_prod;
                3'd2: r_d  <= r_d - r_prod;
                3'd3: r_nv <= r_prod;
                3'd4: r_nv <= r_nv - r_prod;
                3'd5: r_nw <= r_prod;
                3'd6: r_nw <= r_nw - r_prod;
                default: r_d <= r_d;
            endcase
        end
        if (r_state == S_MUL && r_step == 3'd6) begin
            r_rem <= '0;
            r_quo <= dvd_v;
            r_dcnt <= '0;
            r_dsel <= 1'b0;
        end else if (r_state == S_DIV) begin
            if (r_dcnt == DIV_LAST) begin
                r_rem  <= '0;
                r_quo  <= dvd_w;
                r_dcnt <= '0;
                r_dsel <= 1'b1;
                if (r_dsel) begin
                    r_w <= q_s;
                end else begin
                    r_v <= q_s;
                end
            end else begin
                r_rem  <= rem_nx;
                r_quo  <= quo_nx;
                r_dcnt <= r_dcnt + 6'd1;
            end
        end
        if (r_state == S_WGT) begin
            r_su     <= sat_w(u_full);
            r_sv     <= sat_w(56'(r_v));
            r_sw     <= sat_w(56'(r_w));
            r_inside <= !u_full[55] && !r_v[53] && !r_w[53];
            r_acc    <= 36'sd32768;
        end else if (r_state == S_DEP && r_step != 3'd0 && r_step != 3'd4) begin
            r_acc <= r_acc + 36'(r_prod);
        end
        if (r_state == S_DEP && r_step == 3'd4) begin
            r_z <= sat_z(r_acc[35:16]);
        end
        if (r_state == S_CMP) begin
            r_hit <= hit_now;
        end
        if (r_state == S_DONE && out_free) begin
            r_o_hit <= !r_zero && r_hit;
            r_o_u   <= r_zero ? '0 : r_su;
            r_o_v   <= r_zero ? '0 : r_sv;
            r_o_w   <= r_zero ? '0 : r_sw;
            r_o_z   <= (!r_zero && r_hit) ? r_z : '0;
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr     <= '0;
            r_step    <= '0;
            r_zero    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (r_state == S_DONE && out_free) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(STORE - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (!i_empty) begin
                        r_step <= '0;
                        r_zero <= i_job.oob;
                        r_state <= i_job.oob ? S_DONE : S_MUL;
                    end
                end
                S_MUL: begin
                    if (r_step == 3'd6) begin
                        r_step <= '0;
                        if (r_d == '0) begin
                            r_zero  <= 1'b1;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end else begin
                        r_step <= r_step + 3'd1;
                    end
                end
                S_DIV: begin
                    if (r_dcnt == DIV_LAST && r_dsel) begin
                        r_state <= S_WGT;
                    end
                end
                S_WGT: begin
                    r_step  <= '0;
                    r_state <= S_DEP;
                end
                S_DEP: begin
                    if (r_step == 3'd4) begin
                        r_state <= S_RD;
                    end else begin
                        r_step <= r_step + 3'd1;
                    end
                end
                S_RD: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid     = r_o_valid;
    assign o_hit       = r_o_hit;
    assign o_weight_u  = r_o_u;
    assign o_weight_v  = r_o_v;
    assign o_weight_w  = r_o_w;
    assign o_depth_out = r_o_z;

    // A transaction leaves the queue only when the sequencer is free.
    `BDT_ASSERT_NOW(a_pop_idle, i_clk, i_rst_n, o_pop, r_state == S_IDLE && !i_empty,
        "queue popped outside idle")
    // The store is written on a test only for a pixel inside the triangle.
    `BDT_ASSERT_NOW(a_write_inside, i_clk, i_rst_n, r_state == S_CMP && ram_we, r_inside,
        "depth written for an outside pixel")
    // A finished result loads the output register.
    `BDT_ASSERT_NEXT(a_done_out, i_clk, i_rst_n, r_state == S_DONE && out_free, r_o_valid,
        "result not presented")
    // The divider never runs past its last quotient bit.
    `BDT_ASSERT_NOW(a_div_count, i_clk, i_rst_n, r_state == S_DIV, r_dcnt <= DIV_LAST,
        "divider count overrun")

endmodule

// ----- design/barycentric_depth_test_core.sv -----
// Barycentric depth test with an on-chip depth store.
// Input channel: i_valid with o_stall; one transaction carries three vertices
// (Q12.4 x/y, Q8.8 depth) and an integer pixel position.
// Output channel: o_valid with i_stall; one result per input transaction:
// hit flag, three Q2.16 weights and the Q8.8 depth (zero unless hit).
// Configuration: APB-style port, image_width at address 0, image_height at 4.
// Items are accepted into a two-entry queue; the back end works one item at a
// time. Most of the work on an in-bounds item is in the
// restoring divider, which runs 53 steps for each of the two weights;
// out-of-bounds items and degenerate triangles skip the divider.
// After reset the back end clears the depth store to minimum depth, one
// entry a cycle, all MAX_WIDTH*MAX_HEIGHT entries (16384 by default); o_stall
// stays high during that pass. Configuration writes are taken at any time.
// While the receiver stalls, the result holds in the output register, the
// back end waits with the next result, and the queue keeps taking items
// until it is full.
module barycentric_depth_test_core #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_a_x,
    input  logic signed [15:0] i_a_y,
    input  logic signed [15:0] i_a_z,
    input  logic signed [15:0] i_b_x,
    input  logic signed [15:0] i_b_y,
    input  logic signed [15:0] i_b_z,
    input  logic signed [15:0] i_c_x,
    input  logic signed [15:0] i_c_y,
    input  logic signed [15:0] i_c_z,
    input  logic signed [8:0]  i_pixel_x,
    input  logic signed [8:0]  i_pixel_y,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_hit,
    output logic signed [17:0] o_weight_u,
    output logic signed [17:0] o_weight_v,
    output logic signed [17:0] o_weight_w,
    output logic signed [15:0] o_depth_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    import bdt_pkg::*;

    localparam int STORE = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (STORE > 1) ? $clog2(STORE) : 1;
    localparam int QW    = $bits(t_job) + AW;

    t_bstat        bstat;
    t_job          f_job;
    t_job          b_job;
    logic [AW-1:0] f_idx;
    logic [AW-1:0] b_idx;
    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_empty;
    logic [QW-1:0] q_out;

    // Front: configuration, bounds check, edge setup.
    bdt_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .AW         (AW)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_a_x     (i_a_x),
        .i_a_y     (i_a_y),
        .i_a_z     (i_a_z),
        .i_b_x     (i_b_x),
        .i_b_y     (i_b_y),
        .i_b_z     (i_b_z),
        .i_c_x     (i_c_x),
        .i_c_y     (i_c_y),
        .i_c_z     (i_c_z),
        .i_pixel_x (i_pixel_x),
        .i_pixel_y (i_pixel_y),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .i_bstat   (bstat),
        .i_full    (q_full),
        .o_push    (push),
        .o_job     (f_job),
        .o_idx     (f_idx)
    );

    // Queue between front and back.
    bdt_fifo #(
        .WIDTH (QW),
        .DEPTH (2)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_job, f_idx}),
        .i_pop   (pop),
        .o_data  (q_out),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    assign b_job = q_out[QW-1:AW];
    assign b_idx = q_out[AW-1:0];

    // Back: weights, depth, store test and result register.
    bdt_back #(
        .STORE (STORE),
        .AW    (AW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .i_job       (b_job),
        .i_idx       (b_idx),
        .o_pop       (pop),
        .o_bstat     (bstat),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_hit       (o_hit),
        .o_weight_u  (o_weight_u),
        .o_weight_v  (o_weight_v),
        .o_weight_w  (o_weight_w),
        .o_depth_out (o_depth_out)
    );

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import bdt_pkg::*;

    localparam int CLEAR_CYCLES = 128 * 128;
    localparam int SETTLE_CYCLES = 250;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int RANDOM_PER_PHASE = 330;
    localparam int NUM_PHASES = 7;

    // One pixel candidate and the result that it produces.
    typedef struct {
        logic signed [15:0] ax, ay, az, bx, by, bz, cx, cy, cz;
        logic signed [8:0]  px, py;
    } pixel_job_t;

    typedef struct {
        logic               hit;
        logic signed [17:0] u, v, w;
        logic signed [15:0] z;
    } depth_result_t;

    // A row of the directed table: typed rows carry their own expectation.
    typedef struct {
        pixel_job_t    job;
        bit            typed;
        depth_result_t res;
    } directed_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic signed [15:0] i_a_x = '0, i_a_y = '0, i_a_z = '0;
    logic signed [15:0] i_b_x = '0, i_b_y = '0, i_b_z = '0;
    logic signed [15:0] i_c_x = '0, i_c_y = '0, i_c_z = '0;
    logic signed [8:0]  i_pixel_x = '0, i_pixel_y = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic o_hit;
    logic signed [17:0] o_weight_u, o_weight_v, o_weight_w;
    logic signed [15:0] o_depth_out;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    barycentric_depth_test_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_a_x(i_a_x), .i_a_y(i_a_y), .i_a_z(i_a_z),
        .i_b_x(i_b_x), .i_b_y(i_b_y), .i_b_z(i_b_z),
        .i_c_x(i_c_x), .i_c_y(i_c_y), .i_c_z(i_c_z),
        .i_pixel_x(i_pixel_x), .i_pixel_y(i_pixel_y),
        .o_valid(o_valid), .i_stall(i_stall), .o_hit(o_hit),
        .o_weight_u(o_weight_u), .o_weight_v(o_weight_v), .o_weight_w(o_weight_w),
        .o_depth_out(o_depth_out),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state: image size and a private copy of the depth store.
    int unsigned image_w = 128;
    int unsigned image_h = 128;
    shortint zbuf [0:CLEAR_CYCLES-1];
    depth_result_t pending_results[$];
    int mismatches = 0;
    int cycles = 0;
    bit calm = 1'b0;
    int stall_left = 0;

    // Round num * 2^16 / den to nearest, halves away from zero.
    function automatic longint weight_ratio(longint num, longint den);
        longint an;
        longint ad;
        longint q;
        an = (num < 0) ? -num : num;
        ad = (den < 0) ? -den : den;
        q = (an * 131072 + ad) / (2 * ad);
        return ((num < 0) != (den < 0)) ? -q : q;
    endfunction

    function automatic longint clamp(longint x, longint lo, longint hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    // Work out the result of one pixel and update the depth store copy.
    function automatic depth_result_t shade_pixel(pixel_job_t j);
        depth_result_t r;
        longint w_eff, h_eff, e0x, e0y, e1x, e1y, e2x, e2y, den, v, w, u;
        longint su, sv, sw, acc, z, idx;
        r = '{hit: 1'b0, u: '0, v: '0, w: '0, z: '0};
        w_eff = (image_w > 128) ? 128 : image_w;
        h_eff = (image_h > 128) ? 128 : image_h;
        if (j.px < 0 || j.px >= w_eff || j.py < 0 || j.py >= h_eff) return r;
        e0x = longint'(j.bx) - j.ax;
        e0y = longint'(j.by) - j.ay;
        e1x = longint'(j.cx) - j.ax;
        e1y = longint'(j.cy) - j.ay;
        e2x = longint'(j.px) * 16 - j.ax;
        e2y = longint'(j.py) * 16 - j.ay;
        den = e0x * e1y - e0y * e1x;
        if (den == 0) return r;
        v = weight_ratio(e2x * e1y - e2y * e1x, den);
        w = weight_ratio(e0x * e2y - e0y * e2x, den);
        u = 65536 - v - w;
        su = clamp(u, -131072, 131071);
        sv = clamp(v, -131072, 131071);
        sw = clamp(w, -131072, 131071);
        acc = su * j.az + sv * j.bz + sw * j.cz + 32768;
        z = (acc >= 0) ? acc / 65536 : -((-acc + 65535) / 65536);
        z = clamp(z, -32768, 32767);
        idx = (h_eff - j.py - 1) * w_eff + j.px;
        r.u = su[17:0];
        r.v = sv[17:0];
        r.w = sw[17:0];
        if (u >= 0 && v >= 0 && w >= 0 && z >= zbuf[idx]) begin
            zbuf[idx] = shortint'(z);
            r.hit = 1'b1;
            r.z = z[15:0];
        end
        return r;
    endfunction

    function automatic pixel_job_t make_job(int ax, int ay, int az, int bx, int by, int bz,
                                            int cx, int cy, int cz, int px, int py);
        pixel_job_t j;
        j.ax = ax; j.ay = ay; j.az = az;
        j.bx = bx; j.by = by; j.bz = bz;
        j.cx = cx; j.cy = cy; j.cz = cz;
        j.px = px; j.py = py;
        return j;
    endfunction

    // A random candidate: mostly a triangle near a pixel in the image.
    function automatic pixel_job_t random_job();
        pixel_job_t j;
        int sel, reach, cx0, cy0;
        int w_eff, h_eff;
        w_eff = (image_w > 128) ? 128 : image_w;
        h_eff = (image_h > 128) ? 128 : image_h;
        sel = $urandom_range(99);
        j.ax = $urandom; j.ay = $urandom; j.az = $urandom;
        j.bx = $urandom; j.by = $urandom; j.bz = $urandom;
        j.cx = $urandom; j.cy = $urandom; j.cz = $urandom;
        j.px = $urandom; j.py = $urandom;
        if (sel < 12) return j;
        if (w_eff > 0 && h_eff > 0 && sel < 92) begin
            j.px = $urandom_range(w_eff - 1);
            j.py = $urandom_range(h_eff - 1);
        end
        cx0 = int'(j.px) * 16;
        cy0 = int'(j.py) * 16;
        reach = ($urandom_range(3) == 0) ? $urandom_range(2000, 30000) : $urandom_range(8, 600);
        j.ax = clamp(cx0 + int'($urandom_range(2 * reach)) - reach, -32768, 32767);
        j.ay = clamp(cy0 + int'($urandom_range(2 * reach)) - reach, -32768, 32767);
        j.bx = clamp(cx0 + int'($urandom_range(2 * reach)) - reach, -32768, 32767);
        j.by = clamp(cy0 + int'($urandom_range(2 * reach)) - reach, -32768, 32767);
        j.cx = clamp(cx0 + int'($urandom_range(2 * reach)) - reach, -32768, 32767);
        j.cy = clamp(cy0 + int'($urandom_range(2 * reach)) - reach, -32768, 32767);
        if (sel >= 95) begin
            j.cx = j.ax;
            j.cy = j.ay;
        end
        return j;
    endfunction

    // Present one transaction and hold it until the block takes it.
    task automatic send_pixel(pixel_job_t j, bit typed, depth_result_t want);
        depth_result_t r;
        i_a_x = j.ax; i_a_y = j.ay; i_a_z = j.az;
        i_b_x = j.bx; i_b_y = j.by; i_b_z = j.bz;
        i_c_x = j.cx; i_c_y = j.cy; i_c_z = j.cz;
        i_pixel_x = j.px; i_pixel_y = j.py;
        i_valid = 1'b1;
        do @(posedge i_clk); while (o_stall);
        r = shade_pixel(j);
        pending_results.push_back(typed ? want : r);
        @(negedge i_clk);
        if (!calm && $urandom_range(99) >= 70) begin
            i_valid = 1'b0;
            repeat (($urandom_range(19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3))
                @(negedge i_clk);
        end
    endtask

    // Let every result drain, then allow the back end to fall idle.
    task automatic drain_results();
        i_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Register write: setup cycle, then access cycle.
    task automatic reg_write(logic [2:0] addr, logic [31:0] data);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0; paddr = addr; pwdata = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    // Receiver stalls: mostly short, a few long, with quiet stretches.
    always @(negedge i_clk) begin
        if (cycles % 400 == 0) calm = ($urandom_range(3) == 0);
        if (stall_left == 0 && !calm) begin
            if ($urandom_range(99) < 15) stall_left = $urandom_range(1, 3);
            else if ($urandom_range(99) == 0) stall_left = $urandom_range(20, 60);
        end
        i_stall <= (stall_left > 0);
        if (stall_left > 0) stall_left = stall_left - 1;
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        depth_result_t e;
        cycles <= cycles + 1;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result at cycle %0d: expected none, got hit=%0d u=%0d v=%0d w=%0d z=%0d",
                             cycles, o_hit, o_weight_u, o_weight_v, o_weight_w, o_depth_out);
            end else begin
                e = pending_results.pop_front();
                if (o_hit !== e.hit || o_weight_u !== e.u || o_weight_v !== e.v ||
                    o_weight_w !== e.w || o_depth_out !== e.z) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch at cycle %0d: expected hit=%0d u=%0d v=%0d w=%0d z=%0d, got hit=%0d u=%0d v=%0d w=%0d z=%0d",
                                 cycles, e.hit, e.u, e.v, e.w, e.z,
                                 o_hit, o_weight_u, o_weight_v, o_weight_w, o_depth_out);
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    directed_row_t directed[$];
    depth_result_t none;

    initial begin
        int phase_w [NUM_PHASES] = '{128, 8, 1, 255, 0, 5, 3};
        int phase_h [NUM_PHASES] = '{128, 8, 1, 255, 7, 0, 128};
        int n;
        none = '{hit: 1'b0, u: '0, v: '0, w: '0, z: '0};
        for (int i = 0; i < CLEAR_CYCLES; i++) zbuf[i] = -32768;

        // Directed table: bounds, degenerate triangles, field extremes, depth order.
        directed.push_back('{make_job(0, 0, 0, 1024, 0, 0, 0, 1024, 0, -1, 5), 1, none});
        directed.push_back('{make_job(0, 0, 0, 1024, 0, 0, 0, 1024, 0, 5, -256), 1, none});
        directed.push_back('{make_job(0, 0, 0, 1024, 0, 0, 0, 1024, 0, 128, 0), 1, none});
        directed.push_back('{make_job(0, 0, 0, 1024, 0, 0, 0, 1024, 0, 255, 255), 1, none});
        directed.push_back('{make_job(0, 0, 0, 1024, 0, 0, 0, 1024, 0, 0, 128), 1, none});
        directed.push_back('{make_job(16, 16, 5, 16, 16, 9, 400, 400, 3, 10, 10), 1, none});
        directed.push_back('{make_job(0, 0, 0, 160, 160, 0, 320, 320, 0, 3, 3), 1, none});
        directed.push_back('{make_job(0, 0, 256, 1024, 0, 512, 0, 1024, -256, 10, 10), 0, none});
        directed.push_back('{make_job(0, 0, 256, 1024, 0, 512, 0, 1024, -256, 10, 10), 0, none});
        directed.push_back('{make_job(0, 0, -32768, 1024, 0, -32768, 0, 1024, -32768, 10, 10), 0, none});
        directed.push_back('{make_job(0, 0, 32767, 1024, 0, 32767, 0, 1024, 32767, 10, 10), 0, none});
        directed.push_back('{make_job(0, 0, 100, 1024, 0, 100, 0, 1024, 100, 60, 60), 0, none});
        directed.push_back('{make_job(0, 0, 100, 2032, 0, 100, 0, 2032, 100, 0, 0), 0, none});
        directed.push_back('{make_job(0, 0, 100, 2032, 0, 100, 0, 2032, 100, 127, 127), 0, none});
        directed.push_back('{make_job(-32768, -32768, 32767, 32767, -32768, -32768,
                                      -32768, 32767, 0, 0, 0), 0, none});
        directed.push_back('{make_job(32767, 32767, -32768, -32768, 32767, 32767,
                                      32767, -32768, 1, 127, 127), 0, none});
        directed.push_back('{make_job(0, 0, 0, 1, 0, 0, 0, 1, 0, 100, 100), 0, none});
        directed.push_back('{make_job(1000, 1000, 50, 1001, 1000, 60, 1000, 1001, 70, 0, 0), 0, none});
        directed.push_back('{make_job(0, 0, 0, 16, 0, 0, 0, 16, 0, 1, 0), 0, none});
        directed.push_back('{make_job(0, 0, 0, 16, 0, 0, 0, 16, 0, 0, 1), 0, none});
        directed.push_back('{make_job(0, 0, 0, 32, 0, 0, 0, 32, 0, 1, 1), 0, none});

        // Reset; the block clears its depth store before it takes transactions.
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed[k]) send_pixel(directed[k].job, directed[k].typed, directed[k].res);

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p != 0) begin
                drain_results();
                reg_write(ADDR_IMAGE_WIDTH, phase_w[p]);
                reg_write(ADDR_IMAGE_HEIGHT, phase_h[p]);
                image_w = phase_w[p];
                image_h = phase_h[p];
            end
            n = (phase_w[p] == 0 || phase_h[p] == 0) ? 40 : RANDOM_PER_PHASE;
            for (int k = 0; k < n; k++) begin
                send_pixel(random_job(), 1'b0, none);
                // Once per phase the sender waits for everything to come back.
                if (k == n / 2) begin
                    i_valid = 1'b0;
                    while (pending_results.size() != 0) @(negedge i_clk);
                end
            end
        end

        i_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- barycentric_depth_test_core.f -----
+incdir+design
design/bdt_pkg.sv
design/bdt_ram.sv
design/bdt_fifo.sv
design/bdt_front.sv
design/bdt_back.sv
design/barycentric_depth_test_core.sv
bench/tb_top.sv
